/* hw/rtl/hcbp_pkg.sv */
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int TOT_W        = 6;
    localparam int CODE_FIELD_W = 32;
    localparam int LEN_W        = 6;
    localparam int OP_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result of one pass through the shared byte extractor.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [TOT_W-1:0]  rem;
        logic              last;
        logic [PEND_W-1:0] pend;
    } t_ext_res;

endpackage

/* hw/rtl/huffman_code_bit_packer_unit.sv */
// A load word writes the table and gives no result; a flush word goes through S_FLUSH to its word.
// An encode word reads the table in S_LOOK, then emits each completed byte (0 to 4) from S_EMIT,
// holding while the output side stalls. A new word is taken only back in S_IDLE.
// Throughput is set by the shared byte extractor, which produces one byte per cycle while the output is free.
// Reset (synchronous, active low) clears the pending bits, the sequencer and the output valid flag.
// The code table is not cleared; encoding a symbol that was never loaded is undefined.
module huffman_code_bit_packer_unit
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [BYTE_W-1:0]       i_symbol,
    input  logic [CODE_FIELD_W-1:0] i_code_bits,
    input  logic [LEN_W-1:0]        i_code_length,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_byte_valid,
    output logic [2:0]              o_unused_bits,
    output logic                    o_run_last
);

    // Stored codes never exceed the code field, so the limit is the smaller of the two.
    localparam int LEN_LIM = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int CW      = LEN_LIM;
    localparam int LW      = $clog2(LEN_LIM + 1);
    localparam int AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W   = CW + PEND_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [2:0]        r_pcount, n_pcount;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [TOT_W-1:0]  r_total, n_total;
    logic              r_sym_ok, n_sym_ok;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_byte_valid, n_byte_valid;
    logic [2:0]        r_unused, n_unused;
    logic              r_run_last, n_run_last;

    logic              accept;
    logic              sym_in_range;
    logic              slot_free;
    logic [LEN_W-1:0]  len_sat;
    logic [CODE_FIELD_W-1:0] code_masked;
    logic              tbl_we;
    logic              tbl_re;
    logic [CW-1:0]     rd_code;
    logic [LW-1:0]     rd_len;
    logic [ACC_W-1:0]  new_acc;
    logic [TOT_W-1:0]  new_total;
    t_ext_res          ext;

    // No word is taken while reset is held.
    assign o_in_ready   = (r_state == S_IDLE) && i_rst_n;
    assign accept       = i_in_valid && o_in_ready;
    assign sym_in_range = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
    // The output register can take a new word when empty or being drained this cycle.
    assign slot_free    = !r_out_valid || i_out_ready;

    // Load path: saturate the length and clear code bits above it.
    always_comb begin
        len_sat     = (i_code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : i_code_length;
        code_masked = i_code_bits & ~({CODE_FIELD_W{1'b1}} << len_sat);
    end

    assign tbl_we = accept && (t_op'(i_operation) == OP_LOAD) && sym_in_range;
    assign tbl_re = accept && (t_op'(i_operation) == OP_ENCODE) && sym_in_range;

    hcbp_table #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .CW          (CW),
        .LW          (LW),
        .AW          (AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(i_symbol[AW-1:0]),
        .i_wcode(code_masked[CW-1:0]),
        .i_wlen (len_sat[LW-1:0]),
        .i_re   (tbl_re),
        .i_raddr(i_symbol[AW-1:0]),
        .o_rcode(rd_code),
        .o_rlen (rd_len)
    );

    // The looked-up code is appended below the pending bits.
    always_comb begin
        new_acc   = (ACC_W'(r_pend) << rd_len) | ACC_W'(rd_code);
        new_total = TOT_W'(r_pcount) + TOT_W'(rd_len);
    end

    hcbp_extract #(
        .ACC_W(ACC_W)
    ) u_extract (
        .i_acc  (r_acc),
        .i_total(r_total),
        .o_res  (ext)
    );

    // Sequencer: a table read, then one extracted byte per cycle when the output is free; or a flush word.
    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_pcount     = r_pcount;
        n_acc        = r_acc;
        n_total      = r_total;
        n_sym_ok     = r_sym_ok;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_byte_valid = r_byte_valid;
        n_unused     = r_unused;
        n_run_last   = r_run_last;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_operation))
                        OP_ENCODE: begin
                            n_sym_ok = sym_in_range;
                            n_state  = S_LOOK;
                        end
                        OP_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        OP_LOAD, OP_NONE: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // A zero-length code or a symbol beyond the table leaves the stream alone.
                if (!r_sym_ok || (rd_len == '0)) begin
                    n_state = S_IDLE;
                end else if (new_total < TOT_W'(BYTE_W)) begin
                    n_pend   = new_acc[PEND_W-1:0];
                    n_pcount = new_total[2:0];
                    n_state  = S_IDLE;
                end else begin
                    n_acc   = new_acc;
                    n_total = new_total;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = ext.data;
                    n_byte_valid = 1'b1;
                    n_unused     = 3'd0;
                    n_run_last   = ext.last;
                    n_total      = ext.rem;
                    if (ext.last) begin
                        n_pend   = ext.pend;
                        n_pcount = ext.rem[2:0];
                        n_state  = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_run_last  = 1'b1;
                    if (r_pcount == 3'd0) begin
                        // Nothing pending: send the empty marker.
                        n_out_byte   = '0;
                        n_byte_valid = 1'b0;
                        n_unused     = 3'd0;
                    end else begin
                        n_out_byte   = BYTE_W'(r_pend) << (3'd0 - r_pcount);
                        n_byte_valid = 1'b1;
                        n_unused     = 3'd0 - r_pcount;
                    end
                    n_pend   = '0;
                    n_pcount = 3'd0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_pcount    <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pcount    <= n_pcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_total      <= n_total;
        r_sym_ok     <= n_sym_ok;
        r_out_byte   <= n_out_byte;
        r_byte_valid <= n_byte_valid;
        r_unused     <= n_unused;
        r_run_last   <= n_run_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_unused_bits = r_unused;
    assign o_run_last    = r_run_last;

endmodule

/* hw/rtl/hcbp_table.sv */
// Code and length table memory with one write port and one registered read port.
module hcbp_table
    import hcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int CW           = 32,
    parameter int LW           = 6,
    parameter int AW           = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [CW-1:0] i_wcode,
    input  logic [LW-1:0] i_wlen,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [CW-1:0] o_rcode,
    output logic [LW-1:0] o_rlen
);

    logic [CW+LW-1:0] mem [SYMBOL_COUNT];
    logic [CW+LW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wcode, i_wlen};
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rcode = r_rdata[CW+LW-1:LW];
    assign o_rlen  = r_rdata[LW-1:0];

endmodule

/* hw/rtl/hcbp_extract.sv */
// Shared shifter that takes the top complete byte off the bit accumulator.
module hcbp_extract
    import hcbp_pkg::*;
#(
    parameter int ACC_W = 39
) (
    input  logic [ACC_W-1:0] i_acc,
    input  logic [TOT_W-1:0] i_total,
    output t_ext_res         o_res
);

    logic [TOT_W-1:0] rem;
    logic [ACC_W-1:0] shifted;

    always_comb begin
        rem          = i_total - TOT_W'(BYTE_W);
        shifted      = i_acc >> rem;
        o_res.data   = shifted[BYTE_W-1:0];
        o_res.rem    = rem;
        o_res.last   = (rem < TOT_W'(BYTE_W));
        // Bits left below the byte just taken become the new pending bits.
        o_res.pend   = i_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
    end

endmodule

/* test/huffman_code_bit_packer_unit_tb.sv */
// Self-checking testbench for the Huffman code bit packer: directed table, then random words.
module huffman_code_bit_packer_unit_tb;
    import hcbp_pkg::*;

    // The code length that a load can store: the smaller of MAX_CODE_LEN and the
    // width of the code field. The block is built with its default parameters.
    localparam int CODE_LEN_CAP = 32;
    localparam int RAND_WORDS   = 380;
    localparam int MAX_BYTES    = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 60;
    localparam int DRAIN_LIMIT  = 4000;

    // One result word as the output port presents it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic [2:0]        unused;
        logic              last;
    } t_byte_res;

    // One row of the directed table. When exp_typed is set, the row causes exactly
    // one result word, and that word is written out by hand in exp.
    typedef struct {
        t_op                     op;
        logic [BYTE_W-1:0]       sym;
        logic [CODE_FIELD_W-1:0] bits;
        logic [LEN_W-1:0]        len;
        bit                      exp_typed;
        t_byte_res               exp;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation;
    logic [BYTE_W-1:0]       i_symbol;
    logic [CODE_FIELD_W-1:0] i_code_bits;
    logic [LEN_W-1:0]        i_code_length;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [BYTE_W-1:0]       o_out_byte;
    logic                    o_byte_valid;
    logic [2:0]              o_unused_bits;
    logic                    o_run_last;

    // Shadow copy of the code table and of the partial byte under assembly.
    logic [CODE_FIELD_W-1:0] code_mem [256];
    logic [LEN_W-1:0]        len_mem  [256];
    bit                      is_loaded[256];
    logic [BYTE_W-1:0]       loaded_syms[$];
    logic [PEND_W-1:0]       pend_bits;
    int                      pend_cnt;

    // Result words still owed by the block, oldest first.
    t_byte_res               bytes_due[$];
    // Words that the packer produces for the word just accepted.
    t_byte_res               word_res[MAX_BYTES];
    int                      word_res_n;

    t_row                    rows[$];
    bit                      rst_done = 1'b0;
    bit                      no_idle_out = 1'b0;
    int                      fail_count = 0;
    int                      results_checked = 0;
    int                      n_load = 0, n_encode = 0, n_flush = 0, n_ignored = 0;

    huffman_code_bit_packer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_unused_bits (o_unused_bits),
        .o_run_last    (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs. A correct run needs a small fraction of this.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Packs one accepted word into the bit stream and leaves the result words it
    // causes in word_res. A load stores a masked, length-capped code; an encode
    // appends the code below the pending bits and peels off whole bytes from the
    // top; a flush pads the pending bits with zeros up to a byte.
    task automatic pack_word(input t_op op, input logic [BYTE_W-1:0] sym,
                             input logic [CODE_FIELD_W-1:0] bits, input logic [LEN_W-1:0] len);
        logic [63:0] acc;
        int          clen;
        int          total;
        word_res_n = 0;
        case (op)
            OP_LOAD: begin
                clen = (int'(len) > CODE_LEN_CAP) ? CODE_LEN_CAP : int'(len);
                code_mem[sym] = (clen == 0) ? '0 : bits & (32'hFFFF_FFFF >> (32 - clen));
                len_mem[sym]  = LEN_W'(clen);
                if (!is_loaded[sym]) begin
                    is_loaded[sym] = 1'b1;
                    loaded_syms.push_back(sym);
                end
            end
            OP_ENCODE: begin
                clen = int'(len_mem[sym]);
                if (clen != 0) begin
                    acc   = (64'(pend_bits) << clen) | 64'(code_mem[sym]);
                    total = pend_cnt + clen;
                    while (total >= BYTE_W && word_res_n < MAX_BYTES) begin
                        total = total - BYTE_W;
                        word_res[word_res_n] = '{BYTE_W'(acc >> total), 1'b1, 3'd0, 1'b0};
                        word_res_n++;
                    end
                    pend_cnt  = total;
                    pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    if (word_res_n > 0) begin
                        word_res[word_res_n - 1].last = 1'b1;
                    end
                end
            end
            OP_FLUSH: begin
                if (pend_cnt == 0) begin
                    word_res[0] = '{8'h00, 1'b0, 3'd0, 1'b1};
                end else begin
                    word_res[0] = '{BYTE_W'(16'(pend_bits) << (BYTE_W - pend_cnt)), 1'b1,
                                    3'(BYTE_W - pend_cnt), 1'b1};
                end
                word_res_n = 1;
                pend_bits  = '0;
                pend_cnt   = 0;
            end
            default: ;
        endcase
    endtask

    // Offers one word and returns at the edge where it is accepted. Valid only
    // drops when there is a gap to insert, so back-to-back words keep it high.
    task automatic send_word(input t_op op, input logic [BYTE_W-1:0] sym,
                             input logic [CODE_FIELD_W-1:0] bits, input logic [LEN_W-1:0] len,
                             input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_symbol      <= sym;
        i_code_bits   <= bits;
        i_code_length <= len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (op)
            OP_LOAD:   n_load++;
            OP_ENCODE: n_encode++;
            OP_FLUSH:  n_flush++;
            default:   n_ignored++;
        endcase
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
    endfunction

    // Code lengths are mostly short, as real Huffman codes are, with some long ones,
    // some zero-length entries and some lengths past the cap that must saturate.
    function automatic logic [LEN_W-1:0] draw_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return LEN_W'($urandom_range(33, 63));
        if (r < 30) return LEN_W'($urandom_range(13, 32));
        return LEN_W'($urandom_range(1, 12));
    endfunction

    function automatic void report_mismatch(input string what, input t_byte_res want,
                                            input t_byte_res got);
        if (fail_count < 10) begin
            $display("mismatch (%s) at %0t: expected byte %02h valid %0d unused %0d last %0d,",
                     what, $realtime, want.data, want.valid, want.unused, want.last);
            $display("    got byte %02h valid %0d unused %0d last %0d",
                     got.data, got.valid, got.unused, got.last);
        end
        fail_count++;
    endfunction

    // Appends a directed row.
    function automatic void add_row(input t_op op, input logic [BYTE_W-1:0] sym,
                                    input logic [CODE_FIELD_W-1:0] bits,
                                    input logic [LEN_W-1:0] len,
                                    input bit typed, input t_byte_res exp);
        t_row r;
        r.op = op;
        r.sym = sym;
        r.bits = bits;
        r.len = len;
        r.exp_typed = typed;
        r.exp = exp;
        rows.push_back(r);
    endfunction

    // Result side. For every word it draws a random wait with ready low,
    // except during a stretch with no idling. Once, after a number of words has been
    // checked, it holds ready low for a long count of cycles so the block backs up
    // and stalls its input while the sender keeps offering.
    initial begin
        t_byte_res got;
        t_byte_res want;
        int        gap;
        bit        held;
        i_out_ready = 1'b0;
        held = 1'b0;
        wait (rst_done);
        forever begin
            if (!held && results_checked >= HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else if (no_idle_out) begin
                gap = 0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = {o_out_byte, o_byte_valid, o_unused_bits, o_run_last};
            results_checked++;
            if (bytes_due.size() == 0) begin
                report_mismatch("no word expected", '0, got);
            end else begin
                want = bytes_due.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.unused !== want.unused || got.last !== want.last) begin
                    report_mismatch("field", want, got);
                end
            end
        end
    end

    // Word side: reset, the directed table, then random traffic, then the drain.
    initial begin
        t_op                     op;
        logic [BYTE_W-1:0]       sym;
        logic [CODE_FIELD_W-1:0] bits;
        logic [LEN_W-1:0]        len;
        int                      pick;
        int                      gap;
        int                      waited;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_NONE;
        i_symbol      = '0;
        i_code_bits   = '0;
        i_code_length = '0;
        pend_bits     = '0;
        pend_cnt      = 0;
        foreach (is_loaded[k]) is_loaded[k] = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done  = 1'b1;

        // Directed table. Expected words are typed in where they are obvious: the
        // empty marker, a single full byte, and flushed bytes of known padding.
        // Flush straight after reset gives the empty marker.
        add_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, '{8'h00, 1'b0, 3'd0, 1'b1});
        // A length beyond the cap saturates to 32: all ones, longest code.
        add_row(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0, '0);
        add_row(OP_LOAD,   8'hFF, 32'h0000_00A5, 6'd8,  1'b0, '0);
        // Bits above the length are masked off, leaving a single one bit.
        add_row(OP_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd1,  1'b0, '0);
        // A zero-length entry.
        add_row(OP_LOAD,   8'h02, 32'h1234_5678, 6'd0,  1'b0, '0);
        add_row(OP_LOAD,   8'h80, 32'hAAAA_AAAA, 6'd32, 1'b0, '0);
        add_row(OP_LOAD,   8'h7F, 32'h5555_5555, 6'd31, 1'b0, '0);
        add_row(OP_LOAD,   8'h03, 32'hFFFF_FF7F, 6'd7,  1'b0, '0);
        // An eight-bit code on an empty stream comes out as one byte.
        add_row(OP_ENCODE, 8'hFF, 32'h0,         6'd0,  1'b1, '{8'hA5, 1'b1, 3'd0, 1'b1});
        // A zero-length code leaves the stream alone and causes nothing.
        add_row(OP_ENCODE, 8'h02, 32'hFFFF_FFFF, 6'd63, 1'b0, '0);
        add_row(OP_ENCODE, 8'h01, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, '{8'h80, 1'b1, 3'd7, 1'b1});
        // Thirty-two ones on an empty stream: four full bytes, nothing pending.
        add_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, '{8'h00, 1'b0, 3'd0, 1'b1});
        add_row(OP_ENCODE, 8'h01, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_ENCODE, 8'h80, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_ENCODE, 8'h7F, 32'h0,         6'd0,  1'b0, '0);
        // The unused operation code is dropped without a trace.
        add_row(OP_NONE,   8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, '0);
        add_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b0, '0);
        // Seven pending bits plus a 32-bit code: the largest word count, seven left.
        add_row(OP_ENCODE, 8'h03, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  1'b0, '0);
        add_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, '{8'hFE, 1'b1, 3'd1, 1'b1});

        foreach (rows[k]) begin
            send_word(rows[k].op, rows[k].sym, rows[k].bits, rows[k].len, draw_gap());
            // The packer always runs so its state stays in step with the block.
            pack_word(rows[k].op, rows[k].sym, rows[k].bits, rows[k].len);
            if (rows[k].exp_typed) begin
                bytes_due.push_back(rows[k].exp);
            end else begin
                for (int j = 0; j < word_res_n; j++) bytes_due.push_back(word_res[j]);
            end
        end

        // Random traffic: mostly encodes of loaded symbols, with reloads, flushes and
        // the odd unused operation. Fields that an operation ignores still carry noise.
        for (int k = 0; k < RAND_WORDS; k++) begin
            pick = $urandom_range(0, 99);
            sym  = BYTE_W'($urandom_range(0, 255));
            bits = $urandom;
            len  = LEN_W'($urandom_range(0, 63));
            if (pick < 20) begin
                op  = OP_LOAD;
                len = draw_code_len();
            end else if (pick < 82) begin
                op  = OP_ENCODE;
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end else if (pick < 96) begin
                op = OP_FLUSH;
            end else begin
                op = OP_NONE;
            end

            // Once, the sender stops and waits for every owed word to come out.
            if (k == 150) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (bytes_due.size() != 0) @(posedge i_clk);
            end
            // A stretch where neither side idles.
            no_idle_out = (k >= 250 && k < 300);
            gap = no_idle_out ? 0 : draw_gap();

            send_word(op, sym, bits, len, gap);
            pack_word(op, sym, bits, len);
            for (int j = 0; j < word_res_n; j++) bytes_due.push_back(word_res[j]);
        end

        // Drain: wait for every owed word within a bound, then idle a while longer
        // so that a stray extra word would still be caught.
        i_in_valid <= 1'b0;
        no_idle_out = 1'b0;
        waited = 0;
        while (bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (bytes_due.size() != 0) begin
            $display("%0d expected words never arrived", bytes_due.size());
            fail_count += bytes_due.size();
        end

        $display("Sent %0d loads, %0d encodes, %0d flushes and %0d dropped codes;",
                 n_load, n_encode, n_flush, n_ignored);
        $display("checked %0d packed words, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
